@@ design/hid_report_descriptor_parser_assert.svh @@
// assertion macros shared by the checker
`ifndef HID_REPORT_DESCRIPTOR_PARSER_ASSERT_SVH
`define HID_REPORT_DESCRIPTOR_PARSER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define HRDP_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define HRDP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/hrdp_pkg.sv @@
// types and constants of the hid report descriptor parser
package hrdp_pkg;
    localparam logic [7:0] TAG_MASK    = 8'hFC;
    localparam logic [7:0] TAG_PAGE    = 8'h04;
    localparam logic [7:0] TAG_USAGE   = 8'h08;
    localparam logic [7:0] TAG_UMIN    = 8'h18;
    localparam logic [7:0] TAG_LMIN    = 8'h14;
    localparam logic [7:0] TAG_LMAX    = 8'h24;
    localparam logic [7:0] TAG_PMIN    = 8'h34;
    localparam logic [7:0] TAG_PMAX    = 8'h44;
    localparam logic [7:0] TAG_RSIZE   = 8'h74;
    localparam logic [7:0] TAG_RCOUNT  = 8'h94;
    localparam logic [7:0] TAG_RID     = 8'h84;
    localparam logic [7:0] TAG_INPUT   = 8'h80;
    localparam logic [7:0] TAG_OUTPUT  = 8'h90;
    localparam logic [7:0] TAG_FEATURE = 8'hB0;
    localparam logic [7:0] TAG_COLL    = 8'hA0;
    localparam logic [7:0] TAG_ENDCOLL = 8'hC0;
    localparam logic [1:0] KIND_INPUT   = 2'd0;
    localparam logic [1:0] KIND_OUTPUT  = 2'd1;
    localparam logic [1:0] KIND_FEATURE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic       take_byte;   // accept and decode input byte
        logic       clear_all;   // descriptor end: back to reset
        logic       start_emit;  // latch record count, slot 0
        logic       next_slot;   // advance slot after a transaction or a zero-count item
        logic       lookup;      // read usage list for current slot
    } hrdp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       item_done;   // a complete item was decoded
        logic       is_main_io;  // it is input, output or feature
        logic       cnt_zero;    // report count is zero
        logic       last_slot;   // current slot is the final one
    } hrdp_sts_t;
endpackage

@@ design/hrdp_datapath.sv @@
// item decoder, parser state, usage list memory and record builder
module hrdp_datapath #(
    parameter int USAGE_SLOTS  = 64,
    parameter int NEST_DEPTH   = 8,
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  hrdp_pkg::hrdp_cmd_t cmd,
    output hrdp_pkg::hrdp_sts_t sts,
    input  logic [7:0]          byte_in,
    output logic [272:0]        rec_data
);
    import hrdp_pkg::*;
    localparam int UW = $clog2(USAGE_SLOTS);
    localparam int NW = $clog2(NEST_DEPTH);
    localparam int EW = $clog2(MAX_ELEMENTS + 1);

    logic        pending_reg;
    logic [7:0]  tag_reg;
    logic [2:0]  size_reg, got_reg;
    logic [31:0] acc_reg;
    logic [31:0] page_reg, umin_reg, lmin_reg, lmax_reg, pmin_reg, pmax_reg;
    logic [31:0] rsize_reg, rcount_reg, rid_reg;
    logic        umin_valid_reg;
    logic [UW:0] ucount_reg;
    logic [NW:0] depth_reg;
    logic [31:0] usage_mem [USAGE_SLOTS];
    logic [31:0] stack_mem [NEST_DEPTH];
    logic [31:0] udata_reg;
    logic [1:0]  kind_reg;
    logic [31:0] flags_reg;
    logic [EW-1:0] cnt_reg;
    logic [5:0]  slot_reg;
    logic        done_reg, io_reg;

    // decode of the current byte
    logic [7:0]  cur_tag;
    logic [31:0] cur_val;
    logic        cur_done;
    logic [2:0]  psize;
    always_comb begin
        psize    = (byte_in[1:0] == 2'd3) ? 3'd4 : {1'b0, byte_in[1:0]};
        cur_tag  = pending_reg ? tag_reg : (byte_in & TAG_MASK);
        cur_val  = acc_reg | ({24'd0, byte_in} << {got_reg[1:0], 3'b000});
        cur_done = pending_reg ? ((got_reg + 3'd1) >= size_reg) : (psize == 3'd0);
        if (!pending_reg) cur_val = 32'd0;
    end

    // byte gathering and item effects
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_all) begin
            pending_reg <= 1'b0; got_reg <= '0; acc_reg <= '0; size_reg <= '0;
            tag_reg <= '0; page_reg <= '0; umin_reg <= '0; umin_valid_reg <= 1'b0;
            lmin_reg <= '0; lmax_reg <= '0; pmin_reg <= '0; pmax_reg <= '0;
            rsize_reg <= '0; rcount_reg <= '0; rid_reg <= '0;
            ucount_reg <= '0; depth_reg <= '0; done_reg <= 1'b0; io_reg <= 1'b0;
            kind_reg <= KIND_INPUT; flags_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.take_byte) begin
                if (!pending_reg) begin
                    tag_reg <= cur_tag; size_reg <= psize; got_reg <= '0; acc_reg <= '0;
                    pending_reg <= (psize != 3'd0);
                end else begin
                    acc_reg <= cur_val; got_reg <= got_reg + 3'd1;
                    if (cur_done) pending_reg <= 1'b0;
                end
                if (cur_done) begin
                    done_reg  <= 1'b1;
                    io_reg    <= (cur_tag == TAG_INPUT) || (cur_tag == TAG_OUTPUT)
                              || (cur_tag == TAG_FEATURE);
                    flags_reg <= cur_val;
                    kind_reg  <= (cur_tag == TAG_OUTPUT) ? KIND_OUTPUT
                               : (cur_tag == TAG_FEATURE) ? KIND_FEATURE : KIND_INPUT;
                    case (cur_tag)
                        TAG_PAGE:   page_reg <= cur_val;
                        TAG_USAGE: begin
                            umin_valid_reg <= 1'b0;
                            if (ucount_reg < (UW+1)'(USAGE_SLOTS))
                                ucount_reg <= ucount_reg + 1'b1;
                        end
                        TAG_UMIN: begin
                            umin_valid_reg <= 1'b1; umin_reg <= cur_val;
                        end
                        TAG_LMIN:   lmin_reg <= cur_val;
                        TAG_LMAX:   lmax_reg <= cur_val;
                        TAG_PMIN:   pmin_reg <= cur_val;
                        TAG_PMAX:   pmax_reg <= cur_val;
                        TAG_RSIZE:  rsize_reg <= cur_val;
                        TAG_RCOUNT: rcount_reg <= cur_val;
                        TAG_RID:    rid_reg <= cur_val;
                        TAG_COLL: begin
                            if (depth_reg < (NW+1)'(NEST_DEPTH)) depth_reg <= depth_reg + 1'b1;
                            ucount_reg <= '0;
                        end
                        TAG_ENDCOLL: begin
                            if (depth_reg != '0) begin
                                depth_reg <= depth_reg - 1'b1;
                                page_reg  <= stack_mem[NW'(depth_reg - 1'b1)];
                            end
                            ucount_reg <= '0;
                        end
                        default: ;
                    endcase
                end
            end
            // a main item clears the list after its last record, or at once with zero count
            if (cmd.next_slot && (sts.last_slot || sts.cnt_zero)) ucount_reg <= '0;
        end
    end

    // usage list and page stack writes
    always_ff @(posedge aclk) begin
        if (cmd.take_byte && cur_done && cur_tag == TAG_USAGE
            && ucount_reg < (UW+1)'(USAGE_SLOTS))
            usage_mem[UW'(ucount_reg)] <= cur_val;
        if (cmd.take_byte && cur_done && cur_tag == TAG_COLL
            && depth_reg < (NW+1)'(NEST_DEPTH))
            stack_mem[NW'(depth_reg)] <= page_reg;
    end

    // slot counter and usage lookup
    logic [UW:0] rd_idx;
    always_comb begin
        if ({{(UW+1){1'b0}}, slot_reg} < {6'd0, ucount_reg})
            rd_idx = (UW+1)'(slot_reg);
        else
            rd_idx = ucount_reg - 1'b1;
    end
    always_ff @(posedge aclk) begin
        if (cmd.lookup) udata_reg <= usage_mem[UW'(rd_idx)];
    end
    always_ff @(posedge aclk) begin
        if (cmd.start_emit) begin
            slot_reg <= '0;
            cnt_reg  <= (rcount_reg > 32'(MAX_ELEMENTS)) ? EW'(MAX_ELEMENTS)
                      : EW'(rcount_reg);
        end else if (cmd.next_slot) begin
            slot_reg <= slot_reg + 6'd1;
        end
    end

    // status and record
    logic        pz;
    logic [31:0] ucode;
    always_comb begin
        sts.item_done  = done_reg;
        sts.is_main_io = io_reg;
        sts.cnt_zero   = (rcount_reg == 32'd0);
        sts.last_slot  = ({{(EW){1'b0}}, slot_reg} + (EW+6)'(1)) == (EW+6)'(cnt_reg);
        pz    = (pmin_reg == 32'd0) && (pmax_reg == 32'd0);
        ucode = umin_valid_reg ? (umin_reg + {26'd0, slot_reg})
              : (ucount_reg == '0) ? 32'd0 : udata_reg;
        rec_data = {sts.last_slot, slot_reg, rid_reg[7:0], rsize_reg,
                    pz ? lmax_reg : pmax_reg, pz ? lmin_reg : pmin_reg,
                    lmax_reg, lmin_reg, ucode, page_reg, flags_reg, kind_reg};
    end
endmodule

@@ design/hrdp_ctrl.sv @@
// controller state machine of the parser
module hrdp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_end,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  hrdp_pkg::hrdp_sts_t sts,
    output hrdp_pkg::hrdp_cmd_t cmd
);
    import hrdp_pkg::*;
    typedef enum logic [2:0] {ST_IDLE, ST_DECODE, ST_LOOKUP, ST_SHOW, ST_CLEAR} state_t;
    state_t state_reg, state_next;
    logic   end_reg, end_next;

    always_comb begin
        state_next = state_reg;
        end_next   = end_reg;
        cmd        = '0;
        s_tready   = (state_reg == ST_IDLE);
        m_tvalid   = (state_reg == ST_SHOW);
        case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                cmd.take_byte = 1'b1; end_next = s_end; state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (sts.item_done && sts.is_main_io && !sts.cnt_zero) begin
                    cmd.start_emit = 1'b1; state_next = ST_LOOKUP;
                end else if (sts.item_done && sts.is_main_io) begin
                    // zero count still clears the usage list
                    cmd.start_emit = 1'b1; state_next = ST_CLEAR;
                end else begin
                    state_next = end_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1; state_next = ST_SHOW;
            end
            ST_SHOW: if (m_tready) begin
                cmd.next_slot = 1'b1;
                state_next = sts.last_slot ? (end_reg ? ST_CLEAR : ST_IDLE) : ST_LOOKUP;
            end
            ST_CLEAR: begin
                if (end_reg) cmd.clear_all = 1'b1;
                else cmd.next_slot = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; end_reg <= 1'b0;
        end else begin
            state_reg <= state_next; end_reg <= end_next;
        end
    end
endmodule

@@ design/hid_report_descriptor_parser.sv @@
// top level of the hid report descriptor parser
// Usage: descriptor bytes enter on the s_ channel, one per transaction, with
// s_tlast set on the final byte of a descriptor; after that byte all parser
// state returns to its reset value. Each input, output or feature main item
// sends one element record per report slot (report count, capped at
// MAX_ELEMENTS) on the m_ channel; m_tlast marks the item's final record.
// Bytes are taken only in the idle state, never while records go out. Each
// is decoded; a main item with a nonzero report count sends its records,
// each a registered usage list read followed by the output transaction. A
// zero-count main item, and the end mark after any records, pass through a
// clear state before idle. Reset (aresetn low, synchronous) empties the
// parser and drops any partly gathered item.
// While m_tready is low the record holds and no new byte is taken.
module hid_report_descriptor_parser #(
    parameter int USAGE_SLOTS  = 64,
    parameter int NEST_DEPTH   = 8,
    parameter int MAX_ELEMENTS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // descriptor_byte
    input  logic         s_tlast,   // descriptor_end
    output logic         m_tvalid,
    input  logic         m_tready,
    // io_kind, item_flags, page_value, usage_code, logical_low, logical_high,
    // physical_low, physical_high, field_bits, report_number, slot_index
    output logic [271:0] m_tdata,
    output logic         m_tlast    // last
);
    import hrdp_pkg::*;
    hrdp_cmd_t    cmd;
    hrdp_sts_t    sts;
    logic [272:0] rec;

    hrdp_ctrl u_ctrl (.aclk, .aresetn, .s_tvalid, .s_tready, .s_end(s_tlast),
        .m_tvalid, .m_tready, .sts, .cmd);
    hrdp_datapath #(.USAGE_SLOTS(USAGE_SLOTS), .NEST_DEPTH(NEST_DEPTH),
        .MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (.aclk, .aresetn, .cmd, .sts,
        .byte_in(s_tdata), .rec_data(rec));

    // last flag is packed in the top bit of the record
    assign m_tdata = rec[271:0];
    assign m_tlast = rec[272];
endmodule

@@ design/hrdp_checker.sv @@
// port checker for the parser, bound to the top level
`include "hid_report_descriptor_parser_assert.svh"
module hrdp_checker (
    input logic aclk, aresetn, s_tvalid, s_tready, m_tvalid, m_tready, m_tlast,
    input logic [271:0] m_tdata
);
    `HRDP_ASSERT(no_both, s_tready, !m_tvalid)
    `HRDP_ASSERT(kind_ok, m_tvalid, m_tdata[1:0] != 2'd3)
    `HRDP_ASSERT_NEXT(hold_rec, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `HRDP_ASSERT_NEXT(slot_step, m_tvalid && m_tready && !m_tlast, !s_tready)
endmodule

bind hid_report_descriptor_parser hrdp_checker u_chk (.aclk, .aresetn, .s_tvalid,
    .s_tready, .m_tvalid, .m_tready, .m_tlast, .m_tdata);

@@ sim/hid_report_descriptor_parser_tb.sv @@
// testbench for the hid report descriptor parser: byte stream in, element records checked
module hid_report_descriptor_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hrdp_pkg::*;

    localparam int USAGE_SLOTS  = 64;
    localparam int NEST_DEPTH   = 8;
    localparam int MAX_ELEMENTS = 64;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [5:0]  slot_index;
        logic [7:0]  report_number;
        logic [31:0] field_bits;
        logic [31:0] physical_high;
        logic [31:0] physical_low;
        logic [31:0] logical_high;
        logic [31:0] logical_low;
        logic [31:0] usage_code;
        logic [31:0] page_value;
        logic [31:0] item_flags;
        logic [1:0]  io_kind;
    } element_t;

    typedef struct packed {
        logic       fin;
        logic [7:0] data;
    } desc_byte_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [271:0] m_tdata;
    logic         m_tlast;

    hid_report_descriptor_parser #(
        .USAGE_SLOTS(USAGE_SLOTS),
        .NEST_DEPTH(NEST_DEPTH),
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // parser shadow state
    logic        pr_pending;
    logic [7:0]  pr_tag;
    int unsigned pr_size;
    int unsigned pr_gathered;
    logic [31:0] pr_value;
    logic [31:0] pr_page;
    logic [31:0] pr_usages [USAGE_SLOTS];
    int unsigned pr_usage_cnt;
    logic        pr_umin_valid;
    logic [31:0] pr_umin;
    logic [31:0] pr_lmin, pr_lmax, pr_pmin, pr_pmax;
    logic [31:0] pr_rsize, pr_rcount, pr_rid;
    logic [31:0] pr_pages [NEST_DEPTH];
    int unsigned pr_depth;

    element_t   expected_elements[$];
    logic       expected_lasts[$];
    desc_byte_t pending_bytes[$];
    int         error_count = 0;
    int         bytes_sent = 0;
    int         records_seen = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void parser_clear();
        pr_pending = 1'b0; pr_tag = '0; pr_size = 0; pr_gathered = 0; pr_value = '0;
        pr_page = '0; pr_usage_cnt = 0; pr_umin_valid = 1'b0; pr_umin = '0;
        pr_lmin = '0; pr_lmax = '0; pr_pmin = '0; pr_pmax = '0;
        pr_rsize = '0; pr_rcount = '0; pr_rid = '0; pr_depth = 0;
    endfunction

    // queue one record per report slot
    function automatic void emit_records(input logic [1:0] kind, input logic [31:0] flags);
        int unsigned cnt;
        logic        phys_zero;
        element_t    e;
        cnt = (pr_rcount > MAX_ELEMENTS) ? MAX_ELEMENTS : pr_rcount;
        phys_zero = (pr_pmin == 0) && (pr_pmax == 0);
        for (int unsigned j = 0; j < cnt; j++) begin
            if (pr_umin_valid) e.usage_code = pr_umin + j;
            else if (j < pr_usage_cnt) e.usage_code = pr_usages[j];
            else if (pr_usage_cnt > 0) e.usage_code = pr_usages[pr_usage_cnt - 1];
            else e.usage_code = '0;
            e.io_kind = kind;
            e.item_flags = flags;
            e.page_value = pr_page;
            e.logical_low = pr_lmin;
            e.logical_high = pr_lmax;
            e.physical_low = phys_zero ? pr_lmin : pr_pmin;
            e.physical_high = phys_zero ? pr_lmax : pr_pmax;
            e.field_bits = pr_rsize;
            e.report_number = pr_rid[7:0];
            e.slot_index = j[5:0];
            expected_elements.push_back(e);
            expected_lasts.push_back(j + 1 == cnt);
        end
        pr_usage_cnt = 0;
    endfunction

    function automatic void finish_item(input logic [7:0] tag, input logic [31:0] v);
        case (tag)
            TAG_PAGE:   pr_page = v;
            TAG_USAGE: begin
                pr_umin_valid = 1'b0;
                if (pr_usage_cnt < USAGE_SLOTS) begin
                    pr_usages[pr_usage_cnt] = v;
                    pr_usage_cnt++;
                end
            end
            TAG_UMIN: begin
                pr_umin_valid = 1'b1;
                pr_umin = v;
            end
            TAG_LMIN:    pr_lmin = v;
            TAG_LMAX:    pr_lmax = v;
            TAG_PMIN:    pr_pmin = v;
            TAG_PMAX:    pr_pmax = v;
            TAG_RSIZE:   pr_rsize = v;
            TAG_RCOUNT:  pr_rcount = v;
            TAG_RID:     pr_rid = v;
            TAG_INPUT:   emit_records(KIND_INPUT, v);
            TAG_OUTPUT:  emit_records(KIND_OUTPUT, v);
            TAG_FEATURE: emit_records(KIND_FEATURE, v);
            TAG_COLL: begin
                if (pr_depth < NEST_DEPTH) begin
                    pr_pages[pr_depth] = pr_page;
                    pr_depth++;
                end
                pr_usage_cnt = 0;
            end
            TAG_ENDCOLL: begin
                if (pr_depth > 0) begin
                    pr_depth--;
                    pr_page = pr_pages[pr_depth];
                end
                pr_usage_cnt = 0;
            end
            default: ;
        endcase
    endfunction

    // advance the shadow parser by one accepted byte
    function automatic void parse_byte(input logic [7:0] b, input logic fin);
        if (!pr_pending) begin
            pr_tag = b & TAG_MASK;
            pr_size = (b[1:0] == 2'd3) ? 4 : b[1:0];
            pr_gathered = 0;
            pr_value = '0;
            if (pr_size == 0) finish_item(pr_tag, '0);
            else pr_pending = 1'b1;
        end else begin
            pr_value |= 32'(b) << ((pr_gathered % 4) * 8);
            pr_gathered++;
            if (pr_gathered >= pr_size) begin
                pr_pending = 1'b0;
                finish_item(pr_tag, pr_value);
            end
        end
        if (fin) parser_clear();
    endfunction

    // stimulus helpers
    task automatic put_byte(input logic [7:0] b, input logic fin = 1'b0);
        pending_bytes.push_back('{fin: fin, data: b});
    endtask

    task automatic put_item(input logic [7:0] tag, input logic [31:0] v, input int nbytes);
        logic [1:0] code;
        code = (nbytes == 4) ? 2'd3 : nbytes[1:0];
        put_byte(tag | code);
        for (int i = 0; i < nbytes; i++) put_byte(v[8*i +: 8]);
    endtask

    function automatic int rand_len();
        int r;
        r = $urandom_range(0, 9);
        return (r < 2) ? 0 : (r < 5) ? 1 : (r < 8) ? 2 : 4;
    endfunction

    function automatic logic [31:0] rand_value(input int nbytes);
        logic [31:0] v;
        v = $urandom;
        if (nbytes < 4) v &= (32'h1 << (8 * nbytes)) - 1;
        return v;
    endfunction

    // mostly well-formed descriptor fragments with random contents
    task automatic put_random_item(input logic allow_big);
        int unsigned pick;
        int n;
        n = rand_len();
        pick = $urandom_range(0, 19);
        case (pick)
            0, 1: put_item(TAG_PAGE, rand_value(n), n);
            2, 3, 4: put_item(TAG_USAGE, rand_value(n), n);
            5: put_item(TAG_UMIN, rand_value(n), n);
            6: put_item(TAG_LMIN, rand_value(n), n);
            7: put_item(TAG_LMAX, rand_value(n), n);
            8: put_item(TAG_PMIN, ($urandom_range(0, 1) ? rand_value(n) : 0), n);
            9: put_item(TAG_PMAX, ($urandom_range(0, 1) ? rand_value(n) : 0), n);
            10: put_item(TAG_RSIZE, rand_value(n), n);
            11, 12: put_item(TAG_RCOUNT, (allow_big && $urandom_range(0, 9) == 0) ?
                             $urandom_range(0, 100) : $urandom_range(0, 6), 1);
            13: put_item(TAG_RID, rand_value(n), n);
            14: put_item(($urandom_range(0, 2) == 0) ? TAG_OUTPUT :
                         ($urandom_range(0, 1) ? TAG_FEATURE : TAG_INPUT), rand_value(n), n);
            15: put_item(TAG_INPUT, rand_value(n), n);
            16: put_item(TAG_COLL, rand_value(n), n);
            17: put_item(TAG_ENDCOLL, 0, 0);
            default: put_byte($urandom_range(0, 255));
        endcase
    endtask

    logic        hold_off = 1'b0;
    logic        pause_sender = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    logic        in_fire = 1'b0;

    // input transaction seen at the last rising edge
    always @(posedge aclk) in_fire <= s_tvalid && s_tready;

    // driver: bursts with random gaps, inputs change on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_fire) begin
            // hold the offered byte
        end else begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (!pause_sender && burst_left > 0 && pending_bytes.size() > 0) begin
                s_tdata <= pending_bytes[0].data;
                s_tlast <= pending_bytes[0].fin;
                s_tvalid <= 1'b1;
                void'(pending_bytes.pop_front());
                burst_left--;
            end else begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
                else burst_left = 0;
            end
        end
    end

    // receiver stall pattern
    int stall_phase = 0;
    always @(negedge aclk) begin
        stall_phase <= (stall_phase + 1) % 37;
        if (hold_off) m_tready <= 1'b0;
        else if (stall_phase < 12) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 2) != 0);
    end

    // monitor: predict on accepted bytes, check accepted records
    int idle_cycles = 0;
    always @(posedge aclk) begin
        element_t got, want;
        logic     want_last;
        if (aresetn) begin
            idle_cycles++;
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tlast);
                bytes_sent++;
                idle_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                idle_cycles = 0;
                records_seen++;
                got = m_tdata;
                if (expected_elements.size() == 0) begin
                    report_mismatch("unexpected record", '0, '0);
                end else begin
                    want = expected_elements.pop_front();
                    want_last = expected_lasts.pop_front();
                    if (got.io_kind != want.io_kind)
                        report_mismatch("io_kind", got.io_kind, want.io_kind);
                    if (got.item_flags != want.item_flags)
                        report_mismatch("item_flags", got.item_flags, want.item_flags);
                    if (got.page_value != want.page_value)
                        report_mismatch("page_value", got.page_value, want.page_value);
                    if (got.usage_code != want.usage_code)
                        report_mismatch("usage_code", got.usage_code, want.usage_code);
                    if (got.logical_low != want.logical_low)
                        report_mismatch("logical_low", got.logical_low, want.logical_low);
                    if (got.logical_high != want.logical_high)
                        report_mismatch("logical_high", got.logical_high, want.logical_high);
                    if (got.physical_low != want.physical_low)
                        report_mismatch("physical_low", got.physical_low, want.physical_low);
                    if (got.physical_high != want.physical_high)
                        report_mismatch("physical_high", got.physical_high,
                                        want.physical_high);
                    if (got.field_bits != want.field_bits)
                        report_mismatch("field_bits", got.field_bits, want.field_bits);
                    if (got.report_number != want.report_number)
                        report_mismatch("report_number", got.report_number,
                                        want.report_number);
                    if (got.slot_index != want.slot_index)
                        report_mismatch("slot_index", got.slot_index, want.slot_index);
                    if (m_tlast != want_last)
                        report_mismatch("last", m_tlast, want_last);
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || s_tvalid || expected_elements.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        parser_clear();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every main kind, list repeat, fallback limits
        put_item(TAG_PAGE, 32'hFFFF_FFFF, 4);
        put_item(TAG_LMIN, 32'h8000_0000, 4);
        put_item(TAG_LMAX, 32'h7FFF_FFFF, 4);
        put_item(TAG_RSIZE, 8, 1);
        put_item(TAG_RCOUNT, 3, 1);
        put_item(TAG_USAGE, 32'h0000_0030, 1);
        put_item(TAG_USAGE, 32'h0000_0031, 2);
        put_item(TAG_INPUT, 32'h0000_0002, 1);
        put_item(TAG_UMIN, 32'hFFFF_FFFE, 4);
        put_item(TAG_RID, 32'h0000_01FF, 2);
        put_item(TAG_PMIN, 5, 1);
        put_item(TAG_OUTPUT, 0, 0);
        put_item(TAG_COLL, 1, 1);
        put_item(TAG_PAGE, 9, 1);
        put_item(TAG_RCOUNT, 200, 1);
        put_item(TAG_FEATURE, 32'hFFFF_FFFF, 4);
        put_item(TAG_ENDCOLL, 0, 0);
        put_item(TAG_ENDCOLL, 0, 0);
        put_item(TAG_RCOUNT, 0, 1);
        put_item(TAG_INPUT, 0, 0);
        put_byte(8'h00, 1'b1);
        wait_drained();

        // deep nesting past the stack size, then an end in mid item
        for (int i = 0; i < NEST_DEPTH + 2; i++) begin
            put_item(TAG_PAGE, i, 1);
            put_item(TAG_COLL, 0, 0);
        end
        for (int i = 0; i < USAGE_SLOTS + 2; i++) put_item(TAG_USAGE, i, 1);
        put_item(TAG_RCOUNT, MAX_ELEMENTS, 1);
        put_item(TAG_INPUT, 0, 1);
        for (int i = 0; i < NEST_DEPTH + 2; i++) put_item(TAG_ENDCOLL, 0, 0);
        put_item(TAG_RCOUNT, 2, 1);
        put_item(TAG_INPUT, 0, 0);
        put_byte(TAG_LMIN | 2'd3);
        put_byte(8'h55, 1'b1);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
        join_none
        wait_drained();

        // random descriptors
        while (bytes_sent + pending_bytes.size() < 250) begin
            for (int k = $urandom_range(3, 25); k > 0; k--) put_random_item(1'b1);
            if ($urandom_range(0, 2) == 0) put_byte($urandom_range(0, 255), 1'b1);
            while (pending_bytes.size() > 20) @(posedge aclk);
        end
        put_byte(8'h00, 1'b1);

        // sender pause until every record is back
        pause_sender = 1'b1;
        while (expected_elements.size() > 0) @(posedge aclk);
        pause_sender = 1'b0;
        for (int k = 0; k < 30; k++) put_random_item(1'b0);
        put_item(TAG_RCOUNT, 4, 1);
        put_item(TAG_FEATURE, 1, 1);
        put_byte(8'h00, 1'b1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d descriptor bytes and %0d element records, with nesting,",
                 bytes_sent, records_seen);
        $display("usage lists and ranges, capped counts and stalls on both channels");
        if (error_count == 0 && expected_elements.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+design
design/hrdp_pkg.sv
design/hrdp_datapath.sv
design/hrdp_ctrl.sv
design/hid_report_descriptor_parser.sv
design/hrdp_checker.sv
sim/hid_report_descriptor_parser_tb.sv
